[hdl/synth_voice_allocator_assert.svh]
`ifndef SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SVA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("synth_voice_allocator: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SVA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("synth_voice_allocator: assertion failed");

`endif

[hdl/sva_pkg.sv]
`timescale 1ns / 1ps

package sva_pkg;

  localparam int STAMP_W   = 32;
  localparam int CHAN_W    = 4;
  localparam int KEY_W     = 7;
  localparam int VEL_W     = 7;
  localparam int IDX_OUT_W = 4;

  localparam logic KIND_NOTE_ON  = 1'b0;
  localparam logic KIND_NOTE_OFF = 1'b1;

  typedef struct packed {
    logic               gate;
    logic [CHAN_W-1:0]  channel;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } voice_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

endpackage

[hdl/sva_ram.sv]
`timescale 1ns / 1ps

module sva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/synth_voice_allocator.sv]
`timescale 1ns / 1ps
// Polyphonic voice allocator. Each input transaction is a note-on or note-off
// event (kind, channel, key, velocity); each accepted event with a channel
// below CHANNEL_COUNT yields one output transaction naming the voice taken or
// released. Events on a higher channel are accepted and dropped.
// The voice table lives in a single RAM with a registered read. Every event
// reads all VOICE_COUNT entries in turn through a two-stage compare pipeline,
// then writes the chosen entry back; a note-off with no matching voice writes
// nothing. The next event is accepted only after the previous one has
// finished its write-back and the allocator is idle again.
// While an event is in work in_stall is high.
// Reset clears the per-voice valid flags, the event counter and the three valid
// signals; entries never written read as zero, so no clearing pass is needed.
// A stalled result is held in the output register; the next event is still
// accepted and scanned, and only its write-back waits until out_stall drops.
`include "synth_voice_allocator_assert.svh"

module synth_voice_allocator #(
  parameter int VOICE_COUNT   = 16,
  parameter int CHANNEL_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [sva_pkg::CHAN_W-1:0]    channel,
  input  logic [sva_pkg::KEY_W-1:0]     key,
  input  logic [sva_pkg::VEL_W-1:0]     velocity,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sva_pkg::IDX_OUT_W-1:0] voice_index,
  output logic                          hit,
  output logic                          stole_gated,
  output logic                          event_kind,
  output logic [sva_pkg::VEL_W-1:0]     velocity_out
);

  localparam int IDX_W = $clog2(VOICE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);
  localparam int ENTRY_W = $bits(sva_pkg::voice_t);

  sva_pkg::state_t state;

  logic                          ev_kind;
  logic [sva_pkg::CHAN_W-1:0]    ev_channel;
  logic [sva_pkg::KEY_W-1:0]     ev_key;
  logic [sva_pkg::VEL_W-1:0]     ev_velocity;
  logic [sva_pkg::STAMP_W-1:0]   event_counter;
  logic [VOICE_COUNT-1:0]        valid_bits;

  logic                          rd_busy;
  logic [IDX_W-1:0]              rd_idx;
  logic                          p1_valid;
  logic                          p1_live;
  logic [IDX_W-1:0]              p1_idx;
  logic                          p2_valid;
  logic [IDX_W-1:0]              p2_idx;
  logic [sva_pkg::STAMP_W-1:0]   p2_age;
  logic                          p2_gate;
  logic                          p2_match;

  logic                          found;
  logic [IDX_W-1:0]              match_idx;
  logic [IDX_W-1:0]              best_idx;
  logic [sva_pkg::STAMP_W-1:0]   best_age;
  logic                          best_gated;

  logic [ENTRY_W-1:0]            ram_q;
  sva_pkg::voice_t               rd_entry;
  sva_pkg::voice_t               wr_entry;
  logic                          ram_we;
  logic                          out_free;
  logic                          is_on;
  logic                          chan_ok;
  logic [IDX_W-1:0]              wr_idx;

  assign in_stall = (state != sva_pkg::ST_IDLE);
  assign chan_ok  = (5'(channel) < 5'(CHANNEL_COUNT));
  assign out_free = !out_valid || !out_stall;
  assign is_on    = (ev_kind == sva_pkg::KIND_NOTE_ON);
  assign wr_idx   = found ? match_idx : best_idx;
  assign ram_we   = (state == sva_pkg::ST_WRITE) && out_free && (is_on || found);
  assign rd_entry = p1_live ? sva_pkg::voice_t'(ram_q) : '0;

  always_comb begin
    wr_entry         = '0;
    wr_entry.gate    = is_on;
    wr_entry.channel = ev_channel;
    wr_entry.key     = ev_key;
    wr_entry.stamp   = event_counter;
  end

  sva_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(VOICE_COUNT)
  ) u_voice_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx),
    .wdata(ENTRY_W'(wr_entry)),
    .re   (rd_busy),
    .raddr(rd_idx),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    p1_idx   <= rd_idx;
    p1_live  <= valid_bits[rd_idx];
    p2_idx   <= p1_idx;
    p2_age   <= event_counter - rd_entry.stamp;
    p2_gate  <= rd_entry.gate;
    p2_match <= rd_entry.gate && (rd_entry.channel == ev_channel) && (rd_entry.key == ev_key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sva_pkg::ST_IDLE;
      event_counter <= '0;
      valid_bits    <= '0;
      rd_busy       <= 1'b0;
      rd_idx        <= '0;
      p1_valid      <= 1'b0;
      p2_valid      <= 1'b0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      p1_valid <= rd_busy;
      p2_valid <= p1_valid;
      if (out_valid && !out_stall && (state != sva_pkg::ST_WRITE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        sva_pkg::ST_IDLE: begin
          if (in_valid && chan_ok) begin
            ev_kind     <= kind;
            ev_channel  <= channel;
            ev_key      <= key;
            ev_velocity <= velocity;
            rd_idx      <= '0;
            rd_busy     <= 1'b1;
            found       <= 1'b0;
            state       <= sva_pkg::ST_SCAN;
          end
        end
        sva_pkg::ST_SCAN: begin
          if (rd_busy) begin
            if (rd_idx == LAST_IDX) begin
              rd_busy <= 1'b0;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
          if (p2_valid) begin
            if (p2_match && !found) begin
              found     <= 1'b1;
              match_idx <= p2_idx;
            end
            if (p2_idx == '0) begin
              best_idx   <= p2_idx;
              best_age   <= p2_age;
              best_gated <= p2_gate;
            end else if (p2_gate) begin
              if (best_gated && (p2_age >= best_age)) begin
                best_idx <= p2_idx;
                best_age <= p2_age;
              end
            end else if (best_gated || (p2_age >= best_age)) begin
              best_idx   <= p2_idx;
              best_age   <= p2_age;
              best_gated <= 1'b0;
            end
            if (p2_idx == LAST_IDX) begin
              state <= sva_pkg::ST_WRITE;
            end
          end
        end
        sva_pkg::ST_WRITE: begin
          if (out_free) begin
            if (is_on || found) begin
              event_counter      <= event_counter + sva_pkg::STAMP_W'(1);
              valid_bits[wr_idx] <= 1'b1;
            end
            out_valid <= 1'b1;
            state     <= sva_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= sva_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == sva_pkg::ST_WRITE) && out_free) begin
      voice_index  <= (is_on || found) ? sva_pkg::IDX_OUT_W'({4'b0, wr_idx}) : '0;
      hit          <= found;
      stole_gated  <= is_on && !found && best_gated;
      event_kind   <= ev_kind;
      velocity_out <= is_on ? ev_velocity : '0;
    end
  end

  `SVA_ASSERT_IMP(a_write_after_scan, clk, rst, ram_we, !rd_busy && !p1_valid && !p2_valid)
  `SVA_ASSERT_NXT(a_counter_only_on_write, clk, rst, !ram_we, $stable(event_counter))
  `SVA_ASSERT_IMP(a_result_from_write, clk, rst, $rose(out_valid), $past(state == sva_pkg::ST_WRITE))
  `SVA_ASSERT_IMP(a_hit_never_steals, clk, rst, out_valid && hit, !stole_gated)

endmodule
